/* src/slt_pkg.sv */
`default_nettype none

package slt_pkg;

    // Table size and the widths that follow from it.
    localparam int DEPTH  = 16;
    localparam int ADDR_W = $clog2(DEPTH);
    localparam int IDX_W  = $clog2(DEPTH + 1);
    localparam int DATA_W = 32;

    // Request actions.
    localparam logic [2:0] ACT_INSERT    = 3'd0;
    localparam logic [2:0] ACT_REMOVE    = 3'd1;
    localparam logic [2:0] ACT_DUMP_ASC  = 3'd2;
    localparam logic [2:0] ACT_DUMP_DESC = 3'd3;
    localparam logic [2:0] ACT_CLEAR     = 3'd4;

    // Result status codes.
    localparam logic [2:0] ST_OK        = 3'd0;
    localparam logic [2:0] ST_FULL      = 3'd1;
    localparam logic [2:0] ST_NOT_FOUND = 3'd2;
    localparam logic [2:0] ST_EMPTY     = 3'd3;
    localparam logic [2:0] ST_ENTRY     = 3'd4;

    // Sequencer states.
    typedef enum logic [2:0] {
        S_IDLE,
        S_INS,
        S_INS_FIN,
        S_REM,
        S_DUMP,
        S_RESP
    } t_state;

    // One result handed from the sequencer to the output register.
    typedef struct packed {
        logic                     valid;
        logic signed [DATA_W-1:0] item;
        logic [2:0]               status;
        logic                     last;
    } t_result;

    // Table memory access for one cycle.
    typedef struct packed {
        logic              we;
        logic [ADDR_W-1:0] waddr;
        logic [DATA_W-1:0] wdata;
        logic              re;
        logic [ADDR_W-1:0] raddr;
    } t_mem_req;

endpackage

`default_nettype wire

/* src/slt_ram.sv */
`default_nettype none

module slt_ram #(
    parameter int DATA_W = 32,
    parameter int DEPTH  = 16,
    parameter int ADDR_W = $clog2(DEPTH)
) (
    input  wire logic              i_clk,
    input  wire logic              i_we,
    input  wire logic [ADDR_W-1:0] i_waddr,
    input  wire logic [DATA_W-1:0] i_wdata,
    input  wire logic              i_re,
    input  wire logic [ADDR_W-1:0] i_raddr,
    output logic      [DATA_W-1:0] o_rdata
);

    logic [DATA_W-1:0] r_mem [DEPTH];

    // One write port and one read port with registered read data.
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            o_rdata <= r_mem[i_raddr];
        end
    end

endmodule

`default_nettype wire

/* src/slt_ctrl.sv */
`default_nettype none

module slt_ctrl (
    input  wire logic                             i_clk,
    input  wire logic                             i_rst_n,
    input  wire logic                             i_valid,
    output logic                                  o_ready,
    input  wire logic [2:0]                       i_action,
    input  wire logic signed [slt_pkg::DATA_W-1:0] i_value,
    input  wire logic                             i_res_free,
    output slt_pkg::t_result                      o_res,
    output slt_pkg::t_mem_req                     o_mem,
    input  wire logic [slt_pkg::DATA_W-1:0]       i_rdata
);

    import slt_pkg::*;

    t_state                   r_state, n_state;
    logic [IDX_W-1:0]         r_idx, n_idx;
    logic [IDX_W-1:0]         r_count, n_count;
    logic signed [DATA_W-1:0] r_value, n_value;
    logic                     r_found, n_found;
    logic                     r_desc, n_desc;
    logic [2:0]               r_stat, n_stat;

    logic [IDX_W-1:0] idx_dec, idx_m2, idx_inc, cnt_dec, dump_addr;
    logic             rd_less, rd_match;

    // Pointer arithmetic and the compares on the read data.
    assign idx_dec   = r_idx - IDX_W'(1);
    assign idx_m2    = r_idx - IDX_W'(2);
    assign idx_inc   = r_idx + IDX_W'(1);
    assign cnt_dec   = r_count - IDX_W'(1);
    assign dump_addr = r_desc ? (cnt_dec - idx_inc) : idx_inc;
    assign rd_less   = $signed(i_rdata) < r_value;
    assign rd_match  = i_rdata == r_value;

    // Control registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_count <= '0;
        end else begin
            r_state <= n_state;
            r_count <= n_count;
        end
    end

    // Working registers of the current request.
    always_ff @(posedge i_clk) begin
        r_idx   <= n_idx;
        r_value <= n_value;
        r_found <= n_found;
        r_desc  <= n_desc;
        r_stat  <= n_stat;
    end

    // Sequencer: next state, memory accesses and results.
    always_comb begin
        n_state = r_state;
        n_idx   = r_idx;
        n_count = r_count;
        n_value = r_value;
        n_found = r_found;
        n_desc  = r_desc;
        n_stat  = r_stat;
        o_ready = 1'b0;
        o_res   = '0;
        o_mem   = '0;

        case (r_state)
            S_IDLE: begin
                // Requests are refused while reset is held.
                o_ready = i_rst_n;
                if (i_valid && i_rst_n) begin
                    n_value = i_value;
                    case (i_action)
                        ACT_INSERT: begin
                            if (r_count == IDX_W'(DEPTH)) begin
                                n_stat  = ST_FULL;
                                n_state = S_RESP;
                            end else if (r_count == '0) begin
                                n_idx   = '0;
                                n_state = S_INS_FIN;
                            end else begin
                                // Walk down from the top entry.
                                n_idx       = r_count;
                                o_mem.re    = 1'b1;
                                o_mem.raddr = cnt_dec[ADDR_W-1:0];
                                n_state     = S_INS;
                            end
                        end
                        ACT_REMOVE: begin
                            if (r_count == '0) begin
                                n_stat  = ST_EMPTY;
                                n_state = S_RESP;
                            end else begin
                                n_idx       = '0;
                                n_found     = 1'b0;
                                o_mem.re    = 1'b1;
                                o_mem.raddr = '0;
                                n_state     = S_REM;
                            end
                        end
                        ACT_DUMP_ASC, ACT_DUMP_DESC: begin
                            if (r_count == '0) begin
                                n_stat  = ST_EMPTY;
                                n_state = S_RESP;
                            end else begin
                                n_idx       = '0;
                                n_desc      = (i_action == ACT_DUMP_DESC);
                                o_mem.re    = 1'b1;
                                o_mem.raddr = (i_action == ACT_DUMP_DESC)
                                              ? cnt_dec[ADDR_W-1:0] : '0;
                                n_state     = S_DUMP;
                            end
                        end
                        ACT_CLEAR: begin
                            n_count = '0;
                            n_stat  = ST_OK;
                            n_state = S_RESP;
                        end
                        default: begin
                            n_stat  = ST_OK;
                            n_state = S_RESP;
                        end
                    endcase
                end
            end

            S_INS: begin
                // Entries that are not smaller move up one place.
                o_mem.we    = 1'b1;
                o_mem.waddr = r_idx[ADDR_W-1:0];
                if (!rd_less) begin
                    o_mem.wdata = i_rdata;
                    o_mem.re    = 1'b1;
                    o_mem.raddr = idx_m2[ADDR_W-1:0];
                    n_idx       = idx_dec;
                    if (r_idx == IDX_W'(1)) begin
                        n_state = S_INS_FIN;
                    end
                end else begin
                    o_mem.wdata = r_value;
                    n_count     = r_count + IDX_W'(1);
                    n_stat      = ST_OK;
                    n_state     = S_RESP;
                end
            end

            S_INS_FIN: begin
                // The new value goes to the bottom slot that was freed.
                o_mem.we    = 1'b1;
                o_mem.waddr = r_idx[ADDR_W-1:0];
                o_mem.wdata = r_value;
                n_count     = r_count + IDX_W'(1);
                n_stat      = ST_OK;
                n_state     = S_RESP;
            end

            S_REM: begin
                // After the first match every entry moves down one place.
                if (r_found) begin
                    o_mem.we    = 1'b1;
                    o_mem.waddr = idx_dec[ADDR_W-1:0];
                    o_mem.wdata = i_rdata;
                end
                o_mem.re    = 1'b1;
                o_mem.raddr = idx_inc[ADDR_W-1:0];
                n_found     = r_found | rd_match;
                n_idx       = idx_inc;
                if (idx_inc == r_count) begin
                    if (r_found || rd_match) begin
                        n_count = cnt_dec;
                        n_stat  = ST_OK;
                    end else begin
                        n_stat  = ST_NOT_FOUND;
                    end
                    n_state = S_RESP;
                end
            end

            S_DUMP: begin
                // One entry per cycle while the output register has room.
                if (i_res_free) begin
                    o_res.valid  = 1'b1;
                    o_res.item   = $signed(i_rdata);
                    o_res.status = ST_ENTRY;
                    o_res.last   = (idx_inc == r_count);
                    o_mem.re     = 1'b1;
                    o_mem.raddr  = dump_addr[ADDR_W-1:0];
                    n_idx        = idx_inc;
                    if (idx_inc == r_count) begin
                        n_state = S_IDLE;
                    end
                end
            end

            S_RESP: begin
                if (i_res_free) begin
                    o_res.valid  = 1'b1;
                    o_res.item   = '0;
                    o_res.status = r_stat;
                    o_res.last   = 1'b1;
                    n_state      = S_IDLE;
                end
            end

            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

endmodule

`default_nettype wire

/* src/sorted_list_table_top.sv */
`default_nettype none

// Sorted table of up to DEPTH (16) signed 32-bit values, kept ascending with
// duplicates in reverse arrival order. A request is taken only while the
// sequencer is idle; the table lives in a single-port-write, single-port-read
// memory and the sequencer walks it one entry per cycle (a dump only while
// the output side takes them) with a less-than and an equality compare. An
// insert moves each entry not smaller than the value up one place, a remove
// moves the entries above the first match down one place; full, empty,
// clear and unknown requests return a status alone. An output register holds
// the result, so a new request can be taken while the previous result waits.

module sorted_list_table_top (
    input  wire logic                              i_clk,
    input  wire logic                              i_rst_n,
    input  wire logic                              i_valid,
    output logic                                   o_ready,
    input  wire logic [2:0]                        i_action,
    input  wire logic signed [slt_pkg::DATA_W-1:0] i_value,
    output logic                                   o_valid,
    input  wire logic                              i_ready,
    output logic signed [slt_pkg::DATA_W-1:0]      o_item,
    output logic [2:0]                             o_status,
    output logic                                   o_last
);

    import slt_pkg::*;

    t_result           res;
    t_mem_req          mem;
    logic [DATA_W-1:0] rdata;
    logic              res_free;

    logic                     r_out_valid;
    logic signed [DATA_W-1:0] r_out_item;
    logic [2:0]               r_out_status;
    logic                     r_out_last;

    assign res_free = !r_out_valid || i_ready;

    slt_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_valid    (i_valid),
        .o_ready    (o_ready),
        .i_action   (i_action),
        .i_value    (i_value),
        .i_res_free (res_free),
        .o_res      (res),
        .o_mem      (mem),
        .i_rdata    (rdata)
    );

    slt_ram #(
        .DATA_W (DATA_W),
        .DEPTH  (DEPTH),
        .ADDR_W (ADDR_W)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (mem.we),
        .i_waddr (mem.waddr),
        .i_wdata (mem.wdata),
        .i_re    (mem.re),
        .i_raddr (mem.raddr),
        .o_rdata (rdata)
    );

    // Output register valid flag.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (res_free) begin
            r_out_valid <= res.valid;
        end
    end

    // Output register payload, loaded whenever a new result arrives.
    always_ff @(posedge i_clk) begin
        if (res_free && res.valid) begin
            r_out_item   <= res.item;
            r_out_status <= res.status;
            r_out_last   <= res.last;
        end
    end

    assign o_valid  = r_out_valid;
    assign o_item   = r_out_item;
    assign o_status = r_out_status;
    assign o_last   = r_out_last;

endmodule

`default_nettype wire
